// File: design/mrp_pkg.sv
// Shared types and constants for the Modbus RTU response parser.
package mrp_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] FC_READ_HOLDING = 8'h03;
   localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
   localparam int         EXC_BIT         = 7;

   localparam int MIN_FRAME       = 5;
   localparam int MIN_WRITE_FRAME = 8;

   localparam int POS_FUNC     = 1;
   localparam int POS_BCOUNT   = 2;
   localparam int POS_ADDR_HI  = 2;
   localparam int POS_ADDR_LO  = 3;
   localparam int POS_VALUE_HI = 4;
   localparam int POS_VALUE_LO = 5;
   localparam int POS_PAYLOAD  = 3;

   localparam logic MODE_BYTE  = 1'b0;
   localparam logic MODE_READ  = 1'b1;
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_ERROR     = 2'd1,
      STAT_CRC       = 2'd2,
      STAT_EXCEPTION = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CRC,
      ST_EVAL,
      ST_FUNC,
      ST_COUNT,
      ST_COPY,
      ST_COPY_HI,
      ST_COPY_LO,
      ST_ADDR_HI,
      ST_ADDR_LO,
      ST_VAL_HI,
      ST_VAL_LO,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       init;
      logic       load;
      logic       step;
      logic [7:0] data;
   } crc_ctrl_type;

   typedef struct packed {
      logic       kind;
      status_type status;
      logic [7:0] reg_count;
      logic [15:0] read_data;
   } rsp_item_type;

endpackage

// File: design/mrp_crc_unit.sv
// Bit-serial Modbus CRC-16 unit: one polynomial step per cycle.
module mrp_crc_unit
   import mrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  crc_ctrl_type ctrl,
   output logic [15:0]  crc_value
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctrl.init) begin
         crc_in = CRC_INIT;
      end else if (ctrl.load) begin
         crc_in = crc_ff ^ {8'h00, ctrl.data};
      end else if (ctrl.step) begin
         if (crc_ff[0]) begin
            crc_in = (crc_ff >> 1) ^ CRC_POLY;
         end else begin
            crc_in = crc_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff;

endmodule

// File: design/mrp_seq.sv
// Frame sequencer: frame buffer, register store, decode and copy steps.
module mrp_seq
   import mrp_pkg::*;
#(
   parameter int FRAME_BYTES = 256,
   parameter int REG_COUNT   = 128
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_mode,
   input  logic [7:0]   req_rx_byte,
   input  logic         req_frame_end,
   input  logic [6:0]   req_read_index,
   input  logic         out_free,
   output logic         res_valid,
   output rsp_item_type res_item,
   output crc_ctrl_type crc_ctrl,
   input  logic [15:0]  crc_value
);

   localparam int CW  = $clog2(FRAME_BYTES + 1);
   localparam int FA  = $clog2(FRAME_BYTES);
   localparam int RCW = (REG_COUNT > 1) ? $clog2(REG_COUNT + 1) : 1;
   localparam int RA  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int XW  = ((RCW > 7) ? RCW : 7) + 1;
   localparam int NW  = ((CW > RCW) ? CW : RCW) + 1;

   state_type    state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic           last_ff, last_in;
   logic [2:0]     bit_ff, bit_in;
   status_type     status_ff, status_in;
   logic           kind_ff, kind_in;
   logic [RCW-1:0] n_ff, n_in;
   logic [RCW-1:0] ri_ff, ri_in;
   logic [FA-1:0]  fp_ff, fp_in;
   logic [7:0]     hi_ff, hi_in;
   logic [RA-1:0]  waddr_ff, waddr_in;
   logic           waddr_ok_ff, waddr_ok_in;
   logic [RCW-1:0] valid_ff, valid_in;
   logic           init_ff, init_in;
   logic           idx_ok_ff, idx_ok_in;

   logic [7:0]     fmem [FRAME_BYTES];
   logic [7:0]     frd_ff;
   logic           fwe, fre;
   logic [FA-1:0]  fwaddr, fraddr;
   logic [15:0]    rmem [REG_COUNT];
   logic [15:0]    rrd_ff;
   logic           rwe, rre;
   logic [RA-1:0]  rwaddr, rraddr;
   logic [15:0]    rwdata;

   logic [XW-1:0]  idx_ext;
   logic [15:0]    addr_word;
   logic [NW-1:0]  bc_half, avail, cap, n_sel;

   assign idx_ext   = XW'(req_read_index);
   assign addr_word = {hi_ff, frd_ff};

   always_comb begin
      bc_half = NW'(frd_ff[7:1]);
      avail   = NW'(cnt_ff - CW'(MIN_FRAME)) >> 1;
      cap     = NW'(REG_COUNT);
      n_sel   = bc_half;
      if (cap < n_sel) begin
         n_sel = cap;
      end
      if (avail < n_sel) begin
         n_sel = avail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COPY;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         n_ff     <= '0;
         ri_ff    <= '0;
         valid_ff <= '0;
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         n_ff     <= n_in;
         ri_ff    <= ri_in;
         valid_ff <= valid_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      bit_ff      <= bit_in;
      status_ff   <= status_in;
      kind_ff     <= kind_in;
      fp_ff       <= fp_in;
      hi_ff       <= hi_in;
      waddr_ff    <= waddr_in;
      waddr_ok_ff <= waddr_ok_in;
      idx_ok_ff   <= idx_ok_in;
   end

   always_ff @(posedge clock) begin
      if (fwe) begin
         fmem[fwaddr] <= req_rx_byte;
      end
      if (fre) begin
         frd_ff <= fmem[fraddr];
      end
   end

   always_ff @(posedge clock) begin
      if (rwe) begin
         rmem[rwaddr] <= rwdata;
      end
      if (rre) begin
         rrd_ff <= rmem[rraddr];
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      last_in     = last_ff;
      bit_in      = bit_ff;
      status_in   = status_ff;
      kind_in     = kind_ff;
      n_in        = n_ff;
      ri_in       = ri_ff;
      fp_in       = fp_ff;
      hi_in       = hi_ff;
      waddr_in    = waddr_ff;
      waddr_ok_in = waddr_ok_ff;
      valid_in    = valid_ff;
      init_in     = init_ff;
      idx_ok_in   = idx_ok_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      fwe         = 1'b0;
      fwaddr      = cnt_ff[FA-1:0];
      fre         = 1'b0;
      fraddr      = fp_ff;
      rwe         = 1'b0;
      rwaddr      = ri_ff[RA-1:0];
      rwdata      = '0;
      rre         = 1'b0;
      rraddr      = RA'(idx_ext);
      crc_ctrl    = '{init: 1'b0, load: 1'b0, step: 1'b0, data: req_rx_byte};

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_READ) begin
                  kind_in   = KIND_READ;
                  status_in = STAT_OK;
                  rre       = 1'b1;
                  idx_ok_in = idx_ext < XW'(REG_COUNT);
                  state_in  = ST_EMIT;
               end else begin
                  kind_in  = KIND_FRAME;
                  last_in  = req_frame_end;
                  if (cnt_ff < CW'(FRAME_BYTES)) begin
                     fwe    = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  crc_ctrl.load = 1'b1;
                  bit_in        = '0;
                  state_in      = ST_CRC;
               end
            end
         end
         ST_CRC: begin
            crc_ctrl.step = 1'b1;
            bit_in        = bit_ff + 1'b1;
            if (bit_ff == 3'd7) begin
               state_in = last_ff ? ST_EVAL : ST_IDLE;
            end
         end
         ST_EVAL: begin
            if (cnt_ff < CW'(MIN_FRAME) || ovf_ff) begin
               status_in = STAT_ERROR;
               state_in  = ST_EMIT;
            end else if (crc_value != 16'h0000) begin
               status_in = STAT_CRC;
               state_in  = ST_EMIT;
            end else begin
               fre      = 1'b1;
               fraddr   = FA'(POS_FUNC);
               state_in = ST_FUNC;
            end
         end
         ST_FUNC: begin
            state_in = ST_EMIT;
            if (frd_ff[EXC_BIT]) begin
               status_in = STAT_EXCEPTION;
            end else if (frd_ff == FC_READ_HOLDING) begin
               fre      = 1'b1;
               fraddr   = FA'(POS_BCOUNT);
               state_in = ST_COUNT;
            end else if (frd_ff == FC_WRITE_SINGLE) begin
               if (cnt_ff < CW'(MIN_WRITE_FRAME)) begin
                  status_in = STAT_ERROR;
               end else begin
                  fre      = 1'b1;
                  fraddr   = FA'(POS_ADDR_HI);
                  state_in = ST_ADDR_HI;
               end
            end else if (frd_ff == FC_WRITE_MULTI) begin
               status_in = STAT_OK;
            end else begin
               status_in = STAT_ERROR;
            end
         end
         ST_COUNT: begin
            n_in     = RCW'(n_sel);
            valid_in = RCW'(n_sel);
            ri_in    = '0;
            fp_in    = FA'(POS_PAYLOAD);
            init_in  = 1'b0;
            state_in = ST_COPY;
         end
         ST_COPY: begin
            if (ri_ff == RCW'(REG_COUNT)) begin
               status_in = STAT_OK;
               state_in  = init_ff ? ST_IDLE : ST_EMIT;
            end else if (ri_ff < n_ff) begin
               fre      = 1'b1;
               state_in = ST_COPY_HI;
            end else begin
               rwe   = 1'b1;
               ri_in = ri_ff + 1'b1;
            end
         end
         ST_COPY_HI: begin
            hi_in    = frd_ff;
            fre      = 1'b1;
            fraddr   = fp_ff + 1'b1;
            state_in = ST_COPY_LO;
         end
         ST_COPY_LO: begin
            rwe      = 1'b1;
            rwdata   = addr_word;
            ri_in    = ri_ff + 1'b1;
            fp_in    = fp_ff + FA'(2);
            state_in = ST_COPY;
         end
         ST_ADDR_HI: begin
            hi_in    = frd_ff;
            fre      = 1'b1;
            fraddr   = FA'(POS_ADDR_LO);
            state_in = ST_ADDR_LO;
         end
         ST_ADDR_LO: begin
            waddr_ok_in = addr_word < 16'(REG_COUNT);
            waddr_in    = RA'(addr_word);
            fre         = 1'b1;
            fraddr      = FA'(POS_VALUE_HI);
            state_in    = ST_VAL_HI;
         end
         ST_VAL_HI: begin
            hi_in    = frd_ff;
            fre      = 1'b1;
            fraddr   = FA'(POS_VALUE_LO);
            state_in = ST_VAL_LO;
         end
         ST_VAL_LO: begin
            rwe       = waddr_ok_ff;
            rwaddr    = waddr_ff;
            rwdata    = addr_word;
            status_in = STAT_OK;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               res_valid = 1'b1;
               if (kind_ff == KIND_FRAME) begin
                  cnt_in        = '0;
                  ovf_in        = 1'b0;
                  crc_ctrl.init = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res_item.kind      = kind_ff;
      res_item.status    = status_ff;
      res_item.reg_count = 8'(valid_ff);
      res_item.read_data = (kind_ff == KIND_READ && idx_ok_ff) ? rrd_ff : 16'h0000;
   end

endmodule

// File: design/modbus_response_parser_top.sv
// Modbus RTU response parser: CRC check, frame decode and register store.
//
// req_ channel: one item per received frame byte (mode 0, frame_end on the
// last byte) or one register read (mode 1, read_index). rsp_ channel: one
// item per frame end (kind 0, status and reg_count) and per read (kind 1,
// read_data). Bytes that are not the last of a frame give no rsp_ item.
// Each byte is accepted, then runs eight steps of the bit-serial CRC unit,
// which sets the byte rate. At frame end EVAL checks length and CRC, FUNC
// the function code, then 0x06 runs the address and value states; a 0x03
// response copies n registers through the COPY, COPY_HI and COPY_LO
// states and the single read port of the frame buffer, and zeroes the
// remaining REG_COUNT - n entries at one per cycle. A read goes from
// accept to the emit state. After reset a clearing pass with req_ready
// low zeroes the register store. Results sit in an output register; when
// the receiver stalls, the block still takes the next item and finishes
// its work, and holds any further result until the output register frees.
module modbus_response_parser_top
   import mrp_pkg::*;
#(
   parameter int FRAME_BYTES = 256,
   parameter int REG_COUNT   = 128
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   input  logic [6:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_reg_count,
   output logic [15:0] rsp_read_data
);

   crc_ctrl_type crc_ctrl;
   logic [15:0]  crc_value;
   logic         res_valid;
   rsp_item_type res_item;
   logic         out_free;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   mrp_crc_unit u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (crc_ctrl),
      .crc_value (crc_value)
   );

   mrp_seq #(
      .FRAME_BYTES (FRAME_BYTES),
      .REG_COUNT   (REG_COUNT)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_rx_byte    (req_rx_byte),
      .req_frame_end  (req_frame_end),
      .req_read_index (req_read_index),
      .out_free       (out_free),
      .res_valid      (res_valid),
      .res_item       (res_item),
      .crc_ctrl       (crc_ctrl),
      .crc_value      (crc_value)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_item_ff.kind;
   assign rsp_status    = rsp_item_ff.status;
   assign rsp_reg_count = rsp_item_ff.reg_count;
   assign rsp_read_data = rsp_item_ff.read_data;

endmodule

// File: design/mrp_checker.sv
// Port-level checks for the response parser and their bind to the top level.
module mrp_checker
   import mrp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_reg_count,
   input logic [15:0] rsp_read_data
);

   a_read_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_READ |-> rsp_status == STAT_OK)
      else $error("register read item with nonzero status");

   a_frame_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FRAME |-> rsp_read_data == 16'h0000)
      else $error("frame status item with nonzero read data");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held high after an accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_status) && $stable(rsp_reg_count) && $stable(rsp_read_data))
      else $error("stalled result item changed");

endmodule

bind modbus_response_parser_top mrp_checker u_mrp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kind      (rsp_kind),
   .rsp_status    (rsp_status),
   .rsp_reg_count (rsp_reg_count),
   .rsp_read_data (rsp_read_data)
);

// File: sim/tb_modbus_response_parser_top.sv
// Testbench for the Modbus RTU response parser: mirrors CRC, decode and register store per item.
module tb_modbus_response_parser_top import mrp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BYTES = 256;
   localparam int REG_COUNT   = 128;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [7:0]  req_rx_byte;
   logic        req_frame_end;
   logic [6:0]  req_read_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_reg_count;
   logic [15:0] rsp_read_data;

   modbus_response_parser_top #(
      .FRAME_BYTES(FRAME_BYTES),
      .REG_COUNT  (REG_COUNT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_rx_byte   (req_rx_byte),
      .req_frame_end (req_frame_end),
      .req_read_index(req_read_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_reg_count (rsp_reg_count),
      .rsp_read_data (rsp_read_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [7:0]   frame_buf [FRAME_BYTES];
   int unsigned  frame_len;
   bit           frame_overflow;
   logic [15:0]  frame_crc;
   logic [15:0]  reg_mirror [REG_COUNT];
   int unsigned  reg_valid;

   rsp_item_type pending_responses[$];
   logic [7:0]   tx_frame[$];

   int sender_idle_pct  = 0;
   int rsp_stall_pct    = 0;
   int hold_off_cycles  = 0;
   int items_sent       = 0;
   int frames_sent      = 0;
   int reads_sent       = 0;
   int results_checked  = 0;
   int fail_count       = 0;
   int status_seen [4]  = '{0, 0, 0, 0};

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
      int k;
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic status_type decode_frame(int unsigned len);
      logic [7:0]  fc;
      int unsigned n;
      int unsigned addr;
      int          i;
      if (len < MIN_FRAME || frame_overflow) return STAT_ERROR;
      if (frame_crc != 16'h0000) return STAT_CRC;
      fc = frame_buf[POS_FUNC];
      if (fc[EXC_BIT]) return STAT_EXCEPTION;
      case (fc)
         FC_READ_HOLDING: begin
            n = frame_buf[POS_BCOUNT] / 2;
            if (n > REG_COUNT) n = REG_COUNT;
            if (n > (len - MIN_FRAME) / 2) n = (len - MIN_FRAME) / 2;
            for (i = 0; i < REG_COUNT; i++) reg_mirror[i] = 16'h0000;
            for (i = 0; i < n; i++) begin
               reg_mirror[i] = {frame_buf[POS_PAYLOAD + 2 * i], frame_buf[POS_PAYLOAD + 2 * i + 1]};
            end
            reg_valid = n;
            return STAT_OK;
         end
         FC_WRITE_SINGLE: begin
            if (len < MIN_WRITE_FRAME) return STAT_ERROR;
            addr = {frame_buf[POS_ADDR_HI], frame_buf[POS_ADDR_LO]};
            if (addr < REG_COUNT) begin
               reg_mirror[addr] = {frame_buf[POS_VALUE_HI], frame_buf[POS_VALUE_LO]};
            end
            return STAT_OK;
         end
         FC_WRITE_MULTI: return STAT_OK;
         default: return STAT_ERROR;
      endcase
   endfunction

   function automatic void predict_parser_response(logic mode, logic [7:0] b, logic last,
                                                   logic [6:0] idx);
      rsp_item_type e;
      e.kind      = KIND_FRAME;
      e.status    = STAT_OK;
      e.read_data = 16'h0000;
      if (mode == MODE_READ) begin
         e.kind      = KIND_READ;
         e.reg_count = reg_valid[7:0];
         e.read_data = (idx < REG_COUNT) ? reg_mirror[idx] : 16'h0000;
         pending_responses.push_back(e);
         return;
      end
      if (frame_len < FRAME_BYTES) begin
         frame_buf[frame_len] = b;
         frame_len++;
      end else begin
         frame_overflow = 1'b1;
      end
      frame_crc = crc16_next(frame_crc, b);
      if (!last) return;
      e.status       = decode_frame(frame_len);
      e.reg_count    = reg_valid[7:0];
      frame_len      = 0;
      frame_overflow = 1'b0;
      frame_crc      = CRC_INIT;
      pending_responses.push_back(e);
   endfunction

   task automatic send_item(logic mode, logic [7:0] b, logic last, logic [6:0] idx);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_rx_byte    <= b;
      req_frame_end  <= last;
      req_read_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_parser_response(mode, b, last, idx);
      items_sent++;
   endtask

   task automatic send_read(logic [6:0] idx);
      send_item(MODE_READ, rand_byte(), 1'($urandom_range(0, 1)), idx);
      reads_sent++;
   endtask

   task automatic send_frame(bit mix_reads);
      int i;
      for (i = 0; i < tx_frame.size(); i++) begin
         if (mix_reads && $urandom_range(0, 9) == 0) send_read(7'($urandom_range(0, 127)));
         send_item(MODE_BYTE, tx_frame[i], i == tx_frame.size() - 1,
                   7'($urandom_range(0, 127)));
      end
      frames_sent++;
   endtask

   task automatic append_crc();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (tx_frame[i]) c = crc16_next(c, tx_frame[i]);
      tx_frame.push_back(c[7:0]);
      tx_frame.push_back(c[15:8]);
   endtask

   task automatic push_random_bytes(int count);
      repeat (count) tx_frame.push_back(rand_byte());
   endtask

   task automatic build_random_frame();
      int         pick;
      int         bc;
      int         plen;
      int         pos;
      logic [7:0] fc;
      tx_frame.delete();
      tx_frame.push_back(rand_byte());
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         bc = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
         plen = bc;
         if ($urandom_range(0, 4) == 0) plen = $urandom_range(0, bc + 4);
         if (plen > 240) plen = 240;
         tx_frame.push_back(FC_READ_HOLDING);
         tx_frame.push_back(8'(bc));
         push_random_bytes(plen);
         append_crc();
      end else if (pick < 55) begin
         tx_frame.push_back(FC_WRITE_SINGLE);
         tx_frame.push_back(($urandom_range(0, 4) == 0) ? rand_byte() : 8'h00);
         tx_frame.push_back(($urandom_range(0, 3) == 0) ? rand_byte()
                                                        : 8'($urandom_range(0, 127)));
         push_random_bytes(2);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) void'(tx_frame.pop_back());
         end else if ($urandom_range(0, 19) == 0) begin
            push_random_bytes($urandom_range(1, 3));
         end
         append_crc();
      end else if (pick < 62) begin
         tx_frame.push_back(FC_WRITE_MULTI);
         push_random_bytes(4);
         append_crc();
      end else if (pick < 72) begin
         tx_frame.push_back({1'b1, 7'($urandom_range(0, 127))});
         push_random_bytes(1);
         append_crc();
      end else if (pick < 80) begin
         fc = {1'b0, 7'($urandom_range(0, 127))};
         if (fc == FC_READ_HOLDING || fc == FC_WRITE_SINGLE || fc == FC_WRITE_MULTI) begin
            fc = 8'h41;
         end
         tx_frame.push_back(fc);
         push_random_bytes($urandom_range(0, 6));
         append_crc();
      end else if (pick < 88) begin
         tx_frame.push_back(($urandom_range(0, 1) == 0) ? FC_READ_HOLDING : FC_WRITE_SINGLE);
         push_random_bytes($urandom_range(3, 8));
         append_crc();
         pos = $urandom_range(0, tx_frame.size() - 1);
         tx_frame[pos] = tx_frame[pos] ^ (8'h01 << $urandom_range(0, 7));
      end else if (pick < 95) begin
         push_random_bytes($urandom_range(0, 3));
      end else begin
         push_random_bytes($urandom_range(0, 10));
      end
   endtask

   function automatic void check_response();
      rsp_item_type e;
      if (pending_responses.size() == 0) begin
         $error("response with no item pending: kind %0d status %0d", rsp_kind, rsp_status);
         fail_count++;
         return;
      end
      e = pending_responses.pop_front();
      if (rsp_kind !== e.kind) begin
         $error("kind mismatch: expected %0d, actual %0d", e.kind, rsp_kind);
         fail_count++;
      end
      if (rsp_status !== e.status) begin
         $error("status mismatch: expected %0d, actual %0d", e.status, rsp_status);
         fail_count++;
      end
      if (rsp_reg_count !== e.reg_count) begin
         $error("reg_count mismatch: expected %0d, actual %0d", e.reg_count, rsp_reg_count);
         fail_count++;
      end
      if (rsp_read_data !== e.read_data) begin
         $error("read_data mismatch: expected %h, actual %h", e.read_data, rsp_read_data);
         fail_count++;
      end
      results_checked++;
      if (e.kind == KIND_FRAME) status_seen[e.status]++;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_response();
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic test_directed_cases();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      send_read(7'd0);
      tx_frame = '{8'h11};
      send_frame(1'b0);
      tx_frame = '{8'h01, FC_WRITE_SINGLE, 8'h00, 8'h7F, 8'hFF, 8'hFF};
      append_crc();
      send_frame(1'b0);
      send_read(7'd127);
      tx_frame = '{8'h01, 8'h83, 8'h02};
      append_crc();
      send_frame(1'b0);
      tx_frame = '{8'h01, FC_READ_HOLDING, 8'h02, 8'hAB, 8'hCD};
      append_crc();
      send_frame(1'b0);
      send_read(7'd127);
      send_read(7'd0);
   endtask

   task automatic test_largest_frames();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      tx_frame = '{8'hF7, FC_READ_HOLDING, 8'hFF};
      push_random_bytes(FRAME_BYTES - 5);
      append_crc();
      send_frame(1'b0);
      send_read(7'd0);
      send_read(7'd124);
      send_read(7'd125);
      send_read(7'd127);
      tx_frame = '{8'hF7, FC_READ_HOLDING, 8'hFF};
      push_random_bytes(FRAME_BYTES - 4);
      append_crc();
      send_frame(1'b0);
      send_read(7'd1);
   endtask

   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      hold_off_cycles = 400;
      repeat (24) send_read(7'($urandom_range(0, 127)));
      build_random_frame();
      send_frame(1'b1);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int item_budget);
      int stop_at;
      stop_at         = items_sent + item_budget;
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      while (items_sent < stop_at) begin
         build_random_frame();
         send_frame(1'b1);
         repeat ($urandom_range(0, 2)) send_read(7'($urandom_range(0, 127)));
      end
   endtask

   initial begin
      req_valid      <= 1'b0;
      req_mode       <= MODE_BYTE;
      req_rx_byte    <= 8'h00;
      req_frame_end  <= 1'b0;
      req_read_index <= 7'd0;
      rsp_ready      <= 1'b0;
      reset          <= 1'b1;
      frame_len      = 0;
      frame_overflow = 1'b0;
      frame_crc      = CRC_INIT;
      reg_valid      = 0;
      foreach (reg_mirror[i]) reg_mirror[i] = 16'h0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_largest_frames();
      test_output_backpressure();
      test_random_traffic(0, 0, 240);
      test_random_traffic(86, 0, 240);
      test_random_traffic(0, 86, 240);
      test_random_traffic(19, 19, 240);

      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (pending_responses.size() != 0) begin
         $error("%0d expected responses never arrived", pending_responses.size());
         fail_count++;
      end

      $display("Run covered %0d items: %0d frames, %0d register reads, %0d responses checked",
               items_sent, frames_sent, reads_sent, results_checked);
      $display("Frame outcomes: ok %0d, error %0d, crc error %0d, exception %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
design/mrp_pkg.sv
design/mrp_crc_unit.sv
design/mrp_seq.sv
design/modbus_response_parser_top.sv
design/mrp_checker.sv
sim/tb_modbus_response_parser_top.sv
